### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

### hdl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Types, constants and control store of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0]  CH_NEWLINE   = 8'd10;
  localparam logic [7:0]  CH_RETURN    = 8'd13;
  localparam logic [7:0]  CH_BACKSPACE = 8'd8;
  localparam logic [7:0]  CH_SPACE     = 8'd32;
  localparam logic [7:0]  COLOR_RESET  = 8'h07;
  localparam logic [15:0] CELL_RESET   = {COLOR_RESET, CH_SPACE};

  typedef logic [2:0] step_t;

  localparam step_t ST_CLEAR  = 3'd0;
  localparam step_t ST_FETCH  = 3'd1;
  localparam step_t ST_PREP   = 3'd2;
  localparam step_t ST_ACCESS = 3'd3;
  localparam step_t ST_FILL   = 3'd4;
  localparam step_t ST_EMIT   = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_FETCH,
    OP_PREP,
    OP_ACCESS,
    OP_FILL,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_CLR_LAST,
    C_IN_VALID,
    C_SCROLL,
    C_FILL_LAST,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jt;
    step_t jf;
  } ctrl_word_t;

  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic scroll;
    logic fill_last;
    logic out_free;
  } status_t;

  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, jt: ST_FETCH, jf: ST_FETCH};
    case (s)
      ST_CLEAR:  w = '{op: OP_CLEAR,  cond: C_CLR_LAST,  jt: ST_FETCH,  jf: ST_CLEAR};
      ST_FETCH:  w = '{op: OP_FETCH,  cond: C_IN_VALID,  jt: ST_PREP,   jf: ST_FETCH};
      ST_PREP:   w = '{op: OP_PREP,   cond: C_ALWAYS,    jt: ST_ACCESS, jf: ST_ACCESS};
      ST_ACCESS: w = '{op: OP_ACCESS, cond: C_SCROLL,    jt: ST_FILL,   jf: ST_EMIT};
      ST_FILL:   w = '{op: OP_FILL,   cond: C_FILL_LAST, jt: ST_EMIT,   jf: ST_FILL};
      ST_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_FREE,  jt: ST_FETCH,  jf: ST_EMIT};
      default:   w = '{op: OP_NOP,    cond: C_ALWAYS,    jt: ST_FETCH,  jf: ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

### hdl/tcw_ram.sv
// ---------------------------------------------------------------------------
// tcw_ram
// Single port RAM, registered read.
// ---------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/tcw_useq.sv
// ---------------------------------------------------------------------------
// tcw_useq
// Step counter and control store; two-way jump on one status condition.
// ---------------------------------------------------------------------------
module tcw_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  tcw_pkg::status_t    status,
  output tcw_pkg::ctrl_word_t ctrl
);

  import tcw_pkg::*;

  step_t      step_r, step_nxt;
  ctrl_word_t word;
  logic       hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    word = ucode(step_r);
    case (word.cond)
      C_ALWAYS:    hit = 1'b1;
      C_CLR_LAST:  hit = status.clr_last;
      C_IN_VALID:  hit = status.in_valid;
      C_SCROLL:    hit = status.scroll;
      C_FILL_LAST: hit = status.fill_last;
      C_OUT_FREE:  hit = status.out_free;
      default:     hit = 1'b1;
    endcase
    step_nxt = hit ? word.jt : word.jf;
  end

  assign ctrl = word;

endmodule

### hdl/tcw_datapath.sv
// ---------------------------------------------------------------------------
// tcw_datapath
// Cursor, scroll offset, cell store and result register, driven per step.
// ---------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcw_pkg::ctrl_word_t ctrl,
  output tcw_pkg::status_t    status,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_func,
  input  logic [7:0]          in_char_code,
  input  logic [4:0]          in_read_row,
  input  logic [6:0]          in_read_col,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_cell_value,
  output logic [4:0]          out_cursor_row,
  output logic [6:0]          out_cursor_col,
  output logic                out_scrolled
);

  import tcw_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [RW-1:0] line_r, line_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    color_r, color_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          func_r, func_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic [4:0]    rr_r, rr_nxt;
  logic [6:0]    rc_r, rc_nxt;
  logic [RW-1:0] prow_r, prow_nxt;
  logic [CW-1:0] acol_r, acol_nxt;
  logic [CW-1:0] fcol_r, fcol_nxt;
  logic          we_r, we_nxt;
  logic          inr_r, inr_nxt;
  logic          scroll_r, scroll_nxt;
  logic [15:0]   value_r, value_nxt;
  logic [15:0]   ocell_r, ocell_nxt;
  logic [4:0]    orow_r, orow_nxt;
  logic [6:0]    ocol_r, ocol_nxt;
  logic          oscr_r, oscr_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr, cell_addr;
  logic [15:0]   ram_wdata, ram_rdata, blank;
  logic [RW-1:0] addr_row;
  logic [CW-1:0] addr_col;
  logic          out_free, in_range, fill_last;

  function automatic logic [RW-1:0] wrap_row(input logic [RW:0] s);
    if (s >= (RW+1)'(ROWS)) begin
      return RW'(s - (RW+1)'(ROWS));
    end
    return RW'(s);
  endfunction

  assign blank     = {color_r, CH_SPACE};
  assign out_free  = !out_valid_r || out_tready;
  assign fill_last = (fcol_r == CW'(COLUMNS - 1));
  assign in_range  = (32'(rr_r) < 32'(ROWS)) && (32'(rc_r) < 32'(COLUMNS));
  assign in_tready = (ctrl.op == OP_FETCH);
  assign cfg_ready = 1'b1;

  assign addr_row  = (ctrl.op == OP_FILL) ? top_r : prow_r;
  assign addr_col  = (ctrl.op == OP_FILL) ? fcol_r : acol_r;
  assign cell_addr = AW'(addr_row) * AW'(COLUMNS) + AW'(addr_col);
  assign ram_addr  = (ctrl.op == OP_CLEAR) ? clr_cnt_r : cell_addr;

  always_comb begin
    logic [RW:0] lnew;
    logic [CW:0] cn1;
    lnew          = {1'b0, line_r};
    cn1           = {1'b0, col_r} + (CW+1)'(1);
    clr_cnt_nxt   = clr_cnt_r;
    top_nxt       = top_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    color_nxt     = cfg_valid ? cfg_data : color_r;
    out_valid_nxt = out_valid_r && !out_tready;
    func_nxt      = func_r;
    ch_nxt        = ch_r;
    rr_nxt        = rr_r;
    rc_nxt        = rc_r;
    prow_nxt      = prow_r;
    acol_nxt      = acol_r;
    fcol_nxt      = fcol_r;
    we_nxt        = we_r;
    inr_nxt       = inr_r;
    scroll_nxt    = scroll_r;
    value_nxt     = value_r;
    ocell_nxt     = ocell_r;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    oscr_nxt      = oscr_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = blank;
    case (ctrl.op)
      OP_CLEAR: begin
        ram_we      = 1'b1;
        ram_wdata   = CELL_RESET;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      OP_FETCH: begin
        if (in_tvalid) begin
          func_nxt = in_func;
          ch_nxt   = in_char_code;
          rr_nxt   = in_read_row;
          rc_nxt   = in_read_col;
        end
      end
      OP_PREP: begin
        fcol_nxt   = '0;
        scroll_nxt = 1'b0;
        we_nxt     = 1'b0;
        value_nxt  = '0;
        inr_nxt    = in_range;
        if (func_r) begin
          prow_nxt = in_range ? wrap_row({1'b0, top_r} + (RW+1)'(rr_r)) : '0;
          acol_nxt = in_range ? CW'(rc_r) : '0;
        end else begin
          prow_nxt = wrap_row({1'b0, top_r} + {1'b0, line_r});
          acol_nxt = col_r;
          case (ch_r)
            CH_NEWLINE: begin
              col_nxt = '0;
              lnew    = {1'b0, line_r} + (RW+1)'(1);
            end
            CH_RETURN: begin
              col_nxt = '0;
            end
            CH_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt   = col_r - CW'(1);
                acol_nxt  = col_r - CW'(1);
                we_nxt    = 1'b1;
                value_nxt = blank;
              end
            end
            default: begin
              we_nxt    = 1'b1;
              value_nxt = {color_r, ch_r};
              if (cn1 == (CW+1)'(COLUMNS)) begin
                col_nxt = '0;
                lnew    = {1'b0, line_r} + (RW+1)'(1);
              end else begin
                col_nxt = CW'(cn1);
              end
            end
          endcase
          if (lnew == (RW+1)'(ROWS)) begin
            scroll_nxt = 1'b1;
            line_nxt   = RW'(ROWS - 1);
          end else begin
            line_nxt   = RW'(lnew);
          end
        end
      end
      OP_ACCESS: begin
        ram_we    = !func_r && we_r;
        ram_re    = func_r;
        ram_wdata = value_r;
      end
      OP_FILL: begin
        ram_we   = 1'b1;
        fcol_nxt = fcol_r + CW'(1);
        if (fill_last) begin
          top_nxt = (top_r == RW'(ROWS - 1)) ? '0 : top_r + RW'(1);
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ocell_nxt     = func_r ? (inr_r ? ram_rdata : '0) : value_r;
          orow_nxt      = 5'(line_r);
          ocol_nxt      = 7'(col_r);
          oscr_nxt      = !func_r && scroll_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      top_r       <= '0;
      line_r      <= '0;
      col_r       <= '0;
      color_r     <= COLOR_RESET;
      out_valid_r <= 1'b0;
      scroll_r    <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      top_r       <= top_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
      scroll_r    <= scroll_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    ch_r    <= ch_nxt;
    rr_r    <= rr_nxt;
    rc_r    <= rc_nxt;
    prow_r  <= prow_nxt;
    acol_r  <= acol_nxt;
    fcol_r  <= fcol_nxt;
    we_r    <= we_nxt;
    inr_r   <= inr_nxt;
    value_r <= value_nxt;
    ocell_r <= ocell_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    oscr_r  <= oscr_nxt;
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    status           = '0;
    status.clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
    status.in_valid  = in_tvalid;
    status.scroll    = scroll_r;
    status.fill_last = fill_last;
    status.out_free  = out_free;
  end

  assign out_tvalid     = out_valid_r;
  assign out_cell_value = ocell_r;
  assign out_cursor_row = orow_r;
  assign out_cursor_col = ocol_r;
  assign out_scrolled   = oscr_r;

endmodule

### hdl/text_console_writer.sv
// ---------------------------------------------------------------------------
// text_console_writer
// Character cell text console with cursor, control characters and scroll.
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    tuser: func; tdata: char, row, col
//   out_     out  out_tvalid/out_tready  tdata: cell, cursor row/col, scrolled
//   cfg_     in   cfg_valid/cfg_ready    cfg_data: text color
//
// One word at a time, in steps: fetch, prepare, store access, emit.
// A scroll adds a fill step that blanks the new bottom row through the single store port.
// After reset the store is blanked one cell a cycle, all ROWS*COLUMNS cells
// (2000 by default); in_tready stays low until then, cfg writes are taken.
// A stalled result holds the emit step; the next word is fetched after.
// ---------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cell_value[15:0], cursor_row[20:16],
                                  // cursor_col[27:21], scrolled[28]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  import tcw_pkg::*;

  ctrl_word_t  ctrl;
  status_t     status;
  logic [15:0] cell_value;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic        scrolled;

  tcw_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .status(status),
    .ctrl  (ctrl)
  );

  tcw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .status        (status),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_func       (in_tuser),
    .in_char_code  (in_tdata[7:0]),
    .in_read_row   (in_tdata[12:8]),
    .in_read_col   (in_tdata[19:13]),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_cell_value(cell_value),
    .out_cursor_row(cursor_row),
    .out_cursor_col(cursor_col),
    .out_scrolled  (scrolled)
  );

  assign out_tdata = {3'b000, scrolled, cursor_col, cursor_row, cell_value};

endmodule

### hdl/tcw_checker.sv
// ---------------------------------------------------------------------------
// tcw_checker
// Port level checks of the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // result word held while stalled
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // no result pending and input not ready out of reset
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid && !in_tready)

  // scroll leaves the cursor on the last row
  `ASSERT_CLK(a_scroll_row, clk, rst_n, out_tvalid && out_tdata[28] |-> out_tdata[20:16] == 5'(ROWS - 1))

  // reported column stays on the line
  `ASSERT_CLK(a_col_range, clk, rst_n, out_tvalid |-> 32'(out_tdata[27:21]) < 32'(COLUMNS))

  // an input word is never taken the cycle after another
  `ASSERT_CLK(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready |=> !in_tready)

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
